// File: hdl/pulse_current_pi_regulator_top_macros.svh
// assertion macros used by the checker in cpr_checker.sv
`ifndef PULSE_CURRENT_PI_REGULATOR_TOP_MACROS_SVH
`define PULSE_CURRENT_PI_REGULATOR_TOP_MACROS_SVH

// same-cycle implication on clk, off while rst_n is low
`define CPR_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed in same cycle");

// next-cycle implication on clk, off while rst_n is low
`define CPR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed in next cycle");

`endif

// File: hdl/cpr_pkg.sv
package cpr_pkg;

  localparam int MAX_TICKS        = 1024;
  localparam int TAIL_START_LEVEL = 2560;
  localparam int SINE_N           = 256;
  localparam int SINE_DEN_BASE    = 5 * SINE_N * SINE_N;

  localparam int DIV_NUM_W = 34;
  localparam int DIV_DEN_W = 19;
  localparam int DIV_CNT_W = 6;

  localparam logic [2:0] PH_SINE    = 3'd0;
  localparam logic [2:0] PH_MODSINE = 3'd1;
  localparam logic [2:0] PH_TAIL    = 3'd2;
  localparam logic [2:0] PH_RISE    = 3'd3;
  localparam logic [2:0] PH_FLAT    = 3'd4;
  localparam logic [2:0] PH_FALL    = 3'd5;
  localparam logic [2:0] PH_BREAK   = 3'd6;

  localparam logic [1:0] SHAPE_SINE    = 2'd0;
  localparam logic [1:0] SHAPE_MODSINE = 2'd1;
  localparam logic [1:0] SHAPE_TRAPEZE = 2'd2;

  localparam logic [2:0] REG_AMPLITUDE = 3'd0;
  localparam logic [2:0] REG_PGAIN     = 3'd1;
  localparam logic [2:0] REG_IGAIN     = 3'd2;
  localparam logic [2:0] REG_ILIMIT    = 3'd3;
  localparam logic [2:0] REG_LENGTH    = 3'd4;
  localparam logic [2:0] REG_SLOPE     = 3'd5;
  localparam logic [2:0] REG_DAC_LIMIT = 3'd6;
  localparam logic [2:0] REG_CONTROL   = 3'd7;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quot;
  } div_rsp_t;

  function automatic logic [2:0] start_phase(input logic [1:0] shape);
    logic [2:0] ph;
    case (shape)
      SHAPE_SINE:    ph = PH_SINE;
      SHAPE_MODSINE: ph = PH_MODSINE;
      SHAPE_TRAPEZE: ph = PH_RISE;
      default:       ph = PH_BREAK;
    endcase
    return ph;
  endfunction

endpackage

// File: hdl/cpr_div.sv
module cpr_div (
  input  logic              clk,
  input  logic              rst_n,
  input  cpr_pkg::div_req_t req,
  output cpr_pkg::div_rsp_t rsp
);
  import cpr_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_DEN_W-1:0] rem_r, rem_nxt;
  logic [DIV_DEN_W-1:0] den_r, den_nxt;
  logic [DIV_NUM_W-1:0] quo_r, quo_nxt;
  logic [DIV_DEN_W:0]   rem_sh;
  logic [DIV_DEN_W:0]   diff;
  logic                 ge;

  assign rem_sh = {rem_r, quo_r[DIV_NUM_W-1]};
  assign diff   = rem_sh - {1'b0, den_r};
  assign ge     = rem_sh >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      den_nxt  = req.den;
      quo_nxt  = req.num;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
      quo_nxt = {quo_r[DIV_NUM_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;

endmodule

// File: hdl/pulse_current_pi_regulator_top.sv
// channel  direction  handshake            payload
// in_      input      in_valid/in_ready    measured_current
// out_     output     out_valid/out_ready  dac_code .. flattop_end_tick
// cfg_     input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// a tick from input transfer to input transfer is short at tick zero and on
// trapeze, tail or break phases, longer on sine phases and longest when a modified
// sine enters its tail; the following-error states are skipped with that check or
// the PI loop off, and a tick after a latched fault goes straight to its result
// the length is set by the shared radix-2 divider, 34 iterations per division,
// used for the sine angle, the sine value and the tail step
// rst_n is synchronous; it loads register reset values and restarts the pulse
// the next tick is taken while a finished result waits on out_ready
module pulse_current_pi_regulator_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [23:0] in_measured_current,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [11:0]        out_dac_code,
  output logic signed [23:0] out_setpoint_current,
  output logic signed [24:0] out_drive_value,
  output logic signed [24:0] out_control_error,
  output logic               out_following_fault,
  output logic               out_pulse_done,
  output logic [10:0]        out_flattop_end_tick,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [27:0]        cfg_data
);
  import cpr_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_FE1  = 4'd1;
  localparam logic [3:0] ST_FE2  = 4'd2;
  localparam logic [3:0] ST_FE3  = 4'd3;
  localparam logic [3:0] ST_PI   = 4'd4;
  localparam logic [3:0] ST_INT  = 4'd5;
  localparam logic [3:0] ST_ISUM = 4'd6;
  localparam logic [3:0] ST_GEN  = 4'd7;
  localparam logic [3:0] ST_DIVK = 4'd8;
  localparam logic [3:0] ST_MULP = 4'd9;
  localparam logic [3:0] ST_DIVS = 4'd10;
  localparam logic [3:0] ST_MULA = 4'd11;
  localparam logic [3:0] ST_DIVT = 4'd12;
  localparam logic [3:0] ST_FIN  = 4'd13;

  // configuration
  logic [22:0] amp_r, amp_nxt;
  logic [23:0] pgain_r, pgain_nxt;
  logic [23:0] igain_r, igain_nxt;
  logic [22:0] ilim_r, ilim_nxt;
  logic [15:0] plen_r, plen_nxt;
  logic [22:0] slope_r, slope_nxt;
  logic [11:0] dlim_r, dlim_nxt;
  logic [27:0] ctrl_r, ctrl_nxt;

  // regulator state
  logic [3:0]         state_r, state_nxt;
  logic [10:0]        tick_r, tick_nxt;
  logic signed [23:0] prev_sp_r, prev_sp_nxt;
  logic signed [24:0] isum_r, isum_nxt;
  logic [15:0]        fe_cnt_r, fe_cnt_nxt;
  logic [2:0]         phase_r, phase_nxt;
  logic [11:0]        tail_r, tail_nxt;
  logic [15:0]        ft_cnt_r, ft_cnt_nxt;
  logic [10:0]        ft_end_r, ft_end_nxt;
  logic               muted_r, muted_nxt;
  logic               fault_r, fault_nxt;
  logic               out_valid_r, out_valid_nxt;

  // working registers
  logic signed [24:0] err_r, err_nxt;
  logic signed [51:0] prod_r, prod_nxt;
  logic [31:0]        lhs_r, lhs_nxt;
  logic signed [35:0] qp_r, qp_nxt;
  logic signed [23:0] sp_r, sp_nxt;
  logic               neg_r, neg_nxt;

  // result registers
  logic [11:0]        o_dac_r, o_dac_nxt;
  logic signed [23:0] o_sp_r, o_sp_nxt;
  logic signed [24:0] o_drive_r, o_drive_nxt;
  logic signed [24:0] o_err_r, o_err_nxt;
  logic               o_fault_r, o_fault_nxt;
  logic               o_done_r, o_done_nxt;
  logic [10:0]        o_ftend_r, o_ftend_nxt;

  // shared multiplier
  logic signed [25:0] mul_a, mul_b;
  logic signed [51:0] mul_p;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [15:0]        len_w;
  logic [24:0]        aerr;
  logic [23:0]        aprev;
  logic [6:0]         allowed;
  logic [15:0]        fe_max;
  logic               no_fe, no_pi, no_dac;
  logic signed [25:0] amp_s, slope_s, tail_s, prev_s;
  logic signed [25:0] gen_cur;
  logic [22:0]        mag;
  logic               fe_ok;
  logic [15:0]        fe_new;
  logic [15:0]        ft_new;
  logic [14:0]        sine_p;
  logic [7:0]         sine_j;
  logic signed [35:0] qi;
  logic signed [37:0] isum_t, ilim_s, drive_t;
  logic signed [24:0] drive;
  logic [15:0]        code;
  logic [1:0]         new_shape;

  cpr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign mul_p = mul_a * mul_b;

  assign len_w   = (plen_r == 16'd0) ? 16'd1 : plen_r;
  assign aerr    = err_r[24] ? 25'(-err_r) : 25'(err_r);
  assign aprev   = prev_sp_r[23] ? 24'(-prev_sp_r) : 24'(prev_sp_r);
  assign allowed = ctrl_r[11:5];
  assign fe_max  = ctrl_r[27:12];
  assign no_fe   = ctrl_r[2];
  assign no_pi   = ctrl_r[3];
  assign no_dac  = ctrl_r[4];
  assign amp_s   = $signed({3'b0, amp_r});
  assign slope_s = $signed({3'b0, slope_r});
  assign tail_s  = $signed({14'b0, tail_r});
  assign prev_s  = 26'(prev_sp_r);
  assign mag     = prod_r[37:15];
  assign sine_j  = div_rsp.quot[7:0];
  assign sine_p  = prod_r[14:0];
  assign qi      = prod_r[51:16];
  assign ilim_s  = $signed({15'b0, ilim_r});

  always_comb begin
    state_nxt     = state_r;
    tick_nxt      = tick_r;
    prev_sp_nxt   = prev_sp_r;
    isum_nxt      = isum_r;
    fe_cnt_nxt    = fe_cnt_r;
    phase_nxt     = phase_r;
    tail_nxt      = tail_r;
    ft_cnt_nxt    = ft_cnt_r;
    ft_end_nxt    = ft_end_r;
    muted_nxt     = muted_r;
    fault_nxt     = fault_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    amp_nxt       = amp_r;
    pgain_nxt     = pgain_r;
    igain_nxt     = igain_r;
    ilim_nxt      = ilim_r;
    plen_nxt      = plen_r;
    slope_nxt     = slope_r;
    dlim_nxt      = dlim_r;
    ctrl_nxt      = ctrl_r;
    err_nxt       = err_r;
    prod_nxt      = prod_r;
    lhs_nxt       = lhs_r;
    qp_nxt        = qp_r;
    sp_nxt        = sp_r;
    neg_nxt       = neg_r;
    o_dac_nxt     = o_dac_r;
    o_sp_nxt      = o_sp_r;
    o_drive_nxt   = o_drive_r;
    o_err_nxt     = o_err_r;
    o_fault_nxt   = o_fault_r;
    o_done_nxt    = o_done_r;
    o_ftend_nxt   = o_ftend_r;
    in_ready      = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    div_req       = '0;
    gen_cur       = '0;
    fe_ok         = 1'b0;
    fe_new        = fe_cnt_r;
    ft_new        = ft_cnt_r;
    isum_t        = '0;
    drive_t       = '0;
    drive         = '0;
    code          = '0;
    new_shape     = ctrl_r[1:0];

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (fault_r) begin
            err_nxt   = '0;
            state_nxt = ST_FIN;
          end else begin
            if (tick_r == 11'd0) begin
              err_nxt     = '0;
              prev_sp_nxt = '0;
              isum_nxt    = '0;
              fe_cnt_nxt  = '0;
            end else begin
              err_nxt = 25'(prev_sp_r) - 25'(in_measured_current);
            end
            state_nxt = (!no_fe && !no_pi) ? ST_FE1 : ST_PI;
          end
        end
      end
      ST_FE1: begin
        mul_a     = $signed({1'b0, aerr});
        mul_b     = 26'sd100;
        prod_nxt  = mul_p;
        state_nxt = ST_FE2;
      end
      ST_FE2: begin
        lhs_nxt   = prod_r[31:0];
        mul_a     = $signed({19'b0, allowed});
        mul_b     = $signed({2'b0, aprev});
        prod_nxt  = mul_p;
        state_nxt = ST_FE3;
      end
      ST_FE3: begin
        if (prev_sp_r == 24'sd0 || tick_r == 11'd0) begin
          fe_ok = (allowed != 7'd0);
        end else begin
          fe_ok = lhs_r < prod_r[31:0];
        end
        if (fe_ok) begin
          fe_new = '0;
        end else if (fe_cnt_r != 16'hFFFF) begin
          fe_new = fe_cnt_r + 16'd1;
        end
        fe_cnt_nxt = fe_new;
        if (fe_new >= fe_max) begin
          fault_nxt = 1'b1;
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_PI;
        end
      end
      ST_PI: begin
        mul_a     = 26'(err_r);
        mul_b     = $signed({2'b0, pgain_r});
        prod_nxt  = mul_p;
        state_nxt = ST_INT;
      end
      ST_INT: begin
        qp_nxt    = qi;
        mul_a     = 26'(err_r);
        mul_b     = $signed({2'b0, igain_r});
        prod_nxt  = mul_p;
        state_nxt = ST_ISUM;
      end
      ST_ISUM: begin
        isum_t = muted_r ? 38'(isum_r) : 38'(isum_r) + 38'(qi);
        if (isum_t > ilim_s) begin
          isum_nxt = 25'(ilim_s);
        end else if (isum_t < -ilim_s) begin
          isum_nxt = 25'(-ilim_s);
        end else begin
          isum_nxt = isum_t[24:0];
        end
        state_nxt = ST_GEN;
      end
      ST_GEN: begin
        state_nxt = ST_FIN;
        if (tick_r == 11'd0) begin
          sp_nxt = '0;
        end else if (tick_r >= 11'(MAX_TICKS)) begin
          sp_nxt    = '0;
          phase_nxt = PH_BREAK;
        end else begin
          case (phase_r)
            PH_SINE, PH_MODSINE: begin
              div_req.start = 1'b1;
              div_req.num   = DIV_NUM_W'({tick_r, 8'b0});
              div_req.den   = DIV_DEN_W'(len_w);
              state_nxt     = ST_DIVK;
            end
            PH_TAIL: gen_cur = prev_s - tail_s;
            PH_RISE: begin
              gen_cur = prev_s + slope_s;
              if (gen_cur >= amp_s) begin
                gen_cur    = amp_s;
                ft_cnt_nxt = '0;
                muted_nxt  = 1'b0;
                phase_nxt  = PH_FLAT;
              end
            end
            PH_FLAT: begin
              gen_cur = prev_s;
              if (ft_cnt_r != 16'hFFFF) begin
                ft_new = ft_cnt_r + 16'd1;
              end
              ft_cnt_nxt = ft_new;
              if (ft_new >= len_w) begin
                ft_end_nxt = tick_r;
                phase_nxt  = PH_FALL;
              end
            end
            PH_FALL: gen_cur = prev_s - slope_s;
            default: gen_cur = '0;
          endcase
          if (gen_cur < 26'sd0) begin
            sp_nxt    = '0;
            phase_nxt = PH_BREAK;
          end else begin
            sp_nxt = gen_cur[23:0];
          end
        end
      end
      ST_DIVK: begin
        if (div_rsp.done) begin
          neg_nxt   = div_rsp.quot[8];
          mul_a     = $signed({18'b0, sine_j});
          mul_b     = $signed(26'(9'(SINE_N) - {1'b0, sine_j}));
          prod_nxt  = mul_p;
          state_nxt = ST_MULP;
        end
      end
      ST_MULP: begin
        div_req.start = 1'b1;
        div_req.num   = {sine_p, 19'b0};
        div_req.den   = DIV_DEN_W'(SINE_DEN_BASE) - {2'b0, sine_p, 2'b0};
        state_nxt     = ST_DIVS;
      end
      ST_DIVS: begin
        if (div_rsp.done) begin
          mul_a     = $signed({3'b0, amp_r});
          mul_b     = $signed({10'b0, div_rsp.quot[15:0]});
          prod_nxt  = mul_p;
          state_nxt = ST_MULA;
        end
      end
      ST_MULA: begin
        gen_cur   = neg_r ? -$signed({3'b0, mag}) : $signed({3'b0, mag});
        state_nxt = ST_FIN;
        if (phase_r == PH_MODSINE && {5'b0, tick_r} > (len_w >> 1) &&
            gen_cur < 26'(TAIL_START_LEVEL)) begin
          gen_cur       = 26'(TAIL_START_LEVEL);
          phase_nxt     = PH_TAIL;
          div_req.start = 1'b1;
          div_req.num   = DIV_NUM_W'(TAIL_START_LEVEL);
          div_req.den   = DIV_DEN_W'(MAX_TICKS) - DIV_DEN_W'(tick_r);
          state_nxt     = ST_DIVT;
        end
        if (gen_cur < 26'sd0) begin
          sp_nxt    = '0;
          phase_nxt = PH_BREAK;
        end else begin
          sp_nxt = gen_cur[23:0];
        end
      end
      ST_DIVT: begin
        if (div_rsp.done) begin
          tail_nxt  = div_rsp.quot[11:0];
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          o_done_nxt    = (phase_r == PH_BREAK);
          o_ftend_nxt   = ft_end_r;
          o_err_nxt     = err_r;
          if (fault_r) begin
            o_dac_nxt   = '0;
            o_sp_nxt    = '0;
            o_drive_nxt = '0;
            o_fault_nxt = 1'b1;
          end else begin
            drive_t = no_pi ? 38'(sp_r) : 38'(sp_r) + 38'(qp_r) + 38'(isum_r);
            if (drive_t > 38'sd16777215) begin
              drive = 25'sd16777215;
            end else if (drive_t < -38'sd16777216) begin
              drive = -25'sd16777216;
            end else begin
              drive = drive_t[24:0];
            end
            code = drive[23:8];
            if (drive <= 25'sd0 || no_dac) begin
              o_dac_nxt = '0;
            end else if (code > {4'b0, dlim_r}) begin
              o_dac_nxt = dlim_r;
            end else begin
              o_dac_nxt = code[11:0];
            end
            o_sp_nxt    = sp_r;
            o_drive_nxt = drive;
            o_fault_nxt = 1'b0;
            prev_sp_nxt = sp_r;
            if (tick_r < 11'(MAX_TICKS)) begin
              tick_nxt = tick_r + 11'd1;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (cfg_valid) begin
      case (cfg_index)
        REG_AMPLITUDE: amp_nxt   = cfg_data[22:0];
        REG_PGAIN:     pgain_nxt = cfg_data[23:0];
        REG_IGAIN:     igain_nxt = cfg_data[23:0];
        REG_ILIMIT:    ilim_nxt  = cfg_data[22:0];
        REG_LENGTH:    plen_nxt  = cfg_data[15:0];
        REG_SLOPE:     slope_nxt = cfg_data[22:0];
        REG_DAC_LIMIT: dlim_nxt  = cfg_data[11:0];
        REG_CONTROL:   ctrl_nxt  = cfg_data;
        default:       ctrl_nxt  = ctrl_r;
      endcase
      new_shape   = ctrl_nxt[1:0];
      tick_nxt    = '0;
      prev_sp_nxt = '0;
      isum_nxt    = '0;
      fe_cnt_nxt  = '0;
      tail_nxt    = '0;
      ft_cnt_nxt  = '0;
      ft_end_nxt  = '0;
      fault_nxt   = 1'b0;
      muted_nxt   = (new_shape == SHAPE_TRAPEZE);
      phase_nxt   = start_phase(new_shape);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      amp_r       <= '0;
      pgain_r     <= '0;
      igain_r     <= '0;
      ilim_r      <= '0;
      plen_r      <= 16'd1;
      slope_r     <= '0;
      dlim_r      <= 12'hFFF;
      ctrl_r      <= '0;
      tick_r      <= '0;
      prev_sp_r   <= '0;
      isum_r      <= '0;
      fe_cnt_r    <= '0;
      phase_r     <= PH_SINE;
      tail_r      <= '0;
      ft_cnt_r    <= '0;
      ft_end_r    <= '0;
      muted_r     <= 1'b0;
      fault_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      amp_r       <= amp_nxt;
      pgain_r     <= pgain_nxt;
      igain_r     <= igain_nxt;
      ilim_r      <= ilim_nxt;
      plen_r      <= plen_nxt;
      slope_r     <= slope_nxt;
      dlim_r      <= dlim_nxt;
      ctrl_r      <= ctrl_nxt;
      tick_r      <= tick_nxt;
      prev_sp_r   <= prev_sp_nxt;
      isum_r      <= isum_nxt;
      fe_cnt_r    <= fe_cnt_nxt;
      phase_r     <= phase_nxt;
      tail_r      <= tail_nxt;
      ft_cnt_r    <= ft_cnt_nxt;
      ft_end_r    <= ft_end_nxt;
      muted_r     <= muted_nxt;
      fault_r     <= fault_nxt;
    end
  end

  always_ff @(posedge clk) begin
    err_r     <= err_nxt;
    prod_r    <= prod_nxt;
    lhs_r     <= lhs_nxt;
    qp_r      <= qp_nxt;
    sp_r      <= sp_nxt;
    neg_r     <= neg_nxt;
    o_dac_r   <= o_dac_nxt;
    o_sp_r    <= o_sp_nxt;
    o_drive_r <= o_drive_nxt;
    o_err_r   <= o_err_nxt;
    o_fault_r <= o_fault_nxt;
    o_done_r  <= o_done_nxt;
    o_ftend_r <= o_ftend_nxt;
  end

  assign cfg_ready            = 1'b1;
  assign out_valid            = out_valid_r;
  assign out_dac_code         = o_dac_r;
  assign out_setpoint_current = o_sp_r;
  assign out_drive_value      = o_drive_r;
  assign out_control_error    = o_err_r;
  assign out_following_fault  = o_fault_r;
  assign out_pulse_done       = o_done_r;
  assign out_flattop_end_tick = o_ftend_r;

endmodule

// File: hdl/cpr_checker.sv
`include "pulse_current_pi_regulator_top_macros.svh"

module cpr_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [11:0]        out_dac_code,
  input logic signed [23:0] out_setpoint_current,
  input logic signed [24:0] out_drive_value,
  input logic               out_following_fault
);

  // a waiting result stays until its transfer
  `CPR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

  // a tick occupies the block, so in_ready drops once it has been accepted
  `CPR_ASSERT_NEXT(a_in_busy, in_valid && in_ready, !in_ready)

  // fault results carry no drive
  `CPR_ASSERT_SAME(a_fault_quiet, out_valid && out_following_fault,
    out_dac_code == 12'd0 && out_setpoint_current == 24'sd0 && out_drive_value == 25'sd0)

  // a nonzero code comes only from a positive drive
  `CPR_ASSERT_SAME(a_dac_sign, out_valid && out_dac_code != 12'd0,
    !out_drive_value[24] && out_drive_value != 25'sd0)

endmodule

bind pulse_current_pi_regulator_top cpr_checker u_cpr_checker (.*);

// File: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import cpr_pkg::*;

  localparam logic [1:0] SHAPE_BAD = 2'd3;
  localparam int ITEM_TARGET = 1600;

  typedef struct {
    logic [11:0]        dac;
    logic signed [23:0] setpoint;
    logic signed [24:0] drive;
    logic signed [24:0] error;
    logic               fault;
    logic               done;
    logic [10:0]        flat_end;
  } tick_result_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic signed [23:0] in_measured_current;
  logic               out_valid;
  logic               out_ready;
  logic [11:0]        out_dac_code;
  logic signed [23:0] out_setpoint_current;
  logic signed [24:0] out_drive_value;
  logic signed [24:0] out_control_error;
  logic               out_following_fault;
  logic               out_pulse_done;
  logic [10:0]        out_flattop_end_tick;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_index;
  logic [27:0]        cfg_data;

  pulse_current_pi_regulator_top i_dut (.*);

  // regulator settings
  longint amplitude, p_gain, i_gain, i_limit, pulse_len, slope, dac_limit;
  logic [27:0] control;
  // regulator state
  int     tick;
  longint prev_sp, isum, tail_dec;
  int     fe_count, flat_count, flat_end;
  logic [2:0] phase;
  bit     i_muted, fault;

  tick_result_t expected_q[$];
  int failures = 0;
  int sent_count = 0;
  bit src_idle = 0;
  bit sink_idle = 0;
  int sink_hold = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("pulse_current_pi_regulator_top: mismatch");
    $finish;
  end

  function automatic void restart_pulse();
    tick = 0;
    prev_sp = 0;
    isum = 0;
    fe_count = 0;
    tail_dec = 0;
    flat_count = 0;
    flat_end = 0;
    fault = 0;
    i_muted = (control[1:0] == SHAPE_TRAPEZE);
    case (control[1:0])
      SHAPE_SINE:    phase = PH_SINE;
      SHAPE_MODSINE: phase = PH_MODSINE;
      SHAPE_TRAPEZE: phase = PH_RISE;
      default:       phase = PH_BREAK;
    endcase
  endfunction

  function automatic longint sine_level(int t, longint len);
    longint k, j, p, s, mag;
    k = ((longint'(t) * SINE_N) / len) % (2 * SINE_N);
    j = k % SINE_N;
    p = j * (SINE_N - j);
    s = (16 * p * 32768) / (5 * SINE_N * SINE_N - 4 * p);
    mag = (amplitude * s) >>> 15;
    return (k >= SINE_N) ? -mag : mag;
  endfunction

  function automatic longint next_setpoint(int t);
    longint len, cur;
    len = (pulse_len != 0) ? pulse_len : 1;
    cur = 0;
    if (t == 0) return 0;
    if (t >= MAX_TICKS) begin
      phase = PH_BREAK;
      return 0;
    end
    case (phase)
      PH_SINE, PH_MODSINE: begin
        cur = sine_level(t, len);
        if (phase == PH_MODSINE && t > len / 2 && cur < TAIL_START_LEVEL) begin
          cur = TAIL_START_LEVEL;
          tail_dec = TAIL_START_LEVEL / (MAX_TICKS - t);
          phase = PH_TAIL;
        end
      end
      PH_TAIL: cur = prev_sp - tail_dec;
      PH_RISE: begin
        cur = prev_sp + slope;
        if (cur >= amplitude) begin
          cur = amplitude;
          flat_count = 0;
          i_muted = 0;
          phase = PH_FLAT;
        end
      end
      PH_FLAT: begin
        cur = prev_sp;
        if (flat_count < 65535) flat_count++;
        if (flat_count >= len) begin
          flat_end = t;
          phase = PH_FALL;
        end
      end
      PH_FALL: cur = prev_sp - slope;
      default: cur = 0;
    endcase
    if (cur < 0) begin
      cur = 0;
      phase = PH_BREAK;
    end
    return cur;
  endfunction

  function automatic tick_result_t regulate_tick(logic signed [23:0] meas);
    tick_result_t r;
    longint err, qp, sp, drive, aerr, aprev, dac;
    bit ok;
    err = 0;
    dac = 0;
    r = '{default: '0};
    r.fault = 1'b1;
    if (!fault) begin
      if (tick == 0) begin
        prev_sp = 0;
        isum = 0;
        fe_count = 0;
      end else begin
        err = prev_sp - longint'(meas);
      end
      if (!control[2] && !control[3]) begin
        aerr = (err < 0) ? -err : err;
        aprev = (prev_sp < 0) ? -prev_sp : prev_sp;
        if (prev_sp == 0 || tick == 0) ok = (control[11:5] != 0);
        else ok = (aerr * 100 < longint'(control[11:5]) * aprev);
        if (ok) fe_count = 0;
        else if (fe_count < 65535) fe_count++;
        if (fe_count >= control[27:12]) begin
          fault = 1;
          r.error = err[24:0];
        end
      end
    end
    if (fault) begin
      r.done = (phase == PH_BREAK);
      r.flat_end = flat_end[10:0];
      return r;
    end
    qp = (err * p_gain) >>> 16;
    if (!i_muted) isum += (err * i_gain) >>> 16;
    if (isum > i_limit) isum = i_limit;
    else if (isum < -i_limit) isum = -i_limit;
    sp = next_setpoint(tick);
    drive = sp + (control[3] ? 0 : qp + isum);
    if (drive > 16777215) drive = 16777215;
    else if (drive < -16777216) drive = -16777216;
    if (drive > 0) begin
      dac = drive >>> 8;
      if (dac > dac_limit) dac = dac_limit;
    end
    if (control[4]) dac = 0;
    if (tick < MAX_TICKS) tick++;
    prev_sp = sp;
    r.dac = dac[11:0];
    r.setpoint = sp[23:0];
    r.drive = drive[24:0];
    r.error = err[24:0];
    r.fault = 1'b0;
    r.done = (phase == PH_BREAK);
    r.flat_end = flat_end[10:0];
    return r;
  endfunction

  function automatic logic [27:0] make_control(logic [1:0] shape, bit no_fe, bit no_pi,
                                               bit no_dac, int allowed, int fe_max);
    logic [27:0] w;
    w = '0;
    w[1:0] = shape;
    w[2] = no_fe;
    w[3] = no_pi;
    w[4] = no_dac;
    w[11:5] = allowed[6:0];
    w[27:12] = fe_max[15:0];
    return w;
  endfunction

  // measured current that follows the previous setpoint closely
  function automatic logic signed [23:0] tracking_current();
    longint span, v;
    span = ((prev_sp < 0) ? -prev_sp : prev_sp) / 128 + 2;
    v = prev_sp + longint'($urandom_range(0, span[31:0])) - span / 2;
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v[23:0];
  endfunction

  task automatic send_tick(input logic signed [23:0] meas);
    int gap;
    gap = src_idle ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_measured_current <= meas;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_q.push_back(regulate_tick(meas));
    sent_count++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [27:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_AMPLITUDE: amplitude = val[22:0];
      REG_PGAIN:     p_gain = val[23:0];
      REG_IGAIN:     i_gain = val[23:0];
      REG_ILIMIT:    i_limit = val[22:0];
      REG_LENGTH:    pulse_len = val[15:0];
      REG_SLOPE:     slope = val[22:0];
      REG_DAC_LIMIT: dac_limit = val[11:0];
      REG_CONTROL:   control = val;
      default: ;
    endcase
    restart_pulse();
    @(posedge clk);
  endtask

  task automatic configure(input longint amp, pg, ig, il, len, slp, dlim,
                           input logic [27:0] ctl);
    drain();
    write_reg(REG_AMPLITUDE, amp[27:0]);
    write_reg(REG_PGAIN, pg[27:0]);
    write_reg(REG_IGAIN, ig[27:0]);
    write_reg(REG_ILIMIT, il[27:0]);
    write_reg(REG_LENGTH, len[27:0]);
    write_reg(REG_SLOPE, slp[27:0]);
    write_reg(REG_DAC_LIMIT, dlim[27:0]);
    write_reg(REG_CONTROL, ctl);
  endtask

  task automatic run_tracking(input int count);
    repeat (count) send_tick(tracking_current());
  endtask

  task automatic test_reset_values();
    send_tick(24'sh7fffff);
    send_tick(-24'sh800000);
    send_tick(24'sh0);
  endtask

  task automatic test_sine();
    configure(23'h10000, 24'h8000, 24'h100, 23'h4000, 8, 0, 4095,
              make_control(SHAPE_SINE, 0, 0, 0, 127, 65535));
    run_tracking(8);
  endtask

  task automatic test_modified_sine();
    configure(23'h8000, 24'h4000, 24'h200, 23'h1000, 16, 0, 4095,
              make_control(SHAPE_MODSINE, 0, 0, 0, 127, 65535));
    run_tracking(14);
  endtask

  task automatic test_trapeze();
    configure(23'h20000, 24'h10000, 24'h800, 23'h8000, 2, 23'h10000, 4095,
              make_control(SHAPE_TRAPEZE, 0, 0, 0, 127, 65535));
    run_tracking(10);
  endtask

  task automatic test_bad_shape();
    configure(23'h20000, 24'h10000, 24'h800, 23'h8000, 0, 23'h10000, 4095,
              make_control(SHAPE_BAD, 0, 0, 0, 127, 65535));
    run_tracking(2);
  endtask

  task automatic test_fault_latch();
    configure(23'h10000, 24'h10000, 24'h100, 23'h4000, 20, 0, 4095,
              make_control(SHAPE_SINE, 0, 0, 0, 0, 3));
    repeat (5) send_tick(24'($urandom));
  endtask

  task automatic test_extremes();
    configure(23'h7fffff, 24'hffffff, 24'hffffff, 23'h7fffff, 65535, 23'h7fffff, 0,
              make_control(SHAPE_SINE, 1, 0, 0, 127, 0));
    send_tick(-24'sh800000);
    send_tick(24'sh7fffff);
    configure(23'h7fffff, 24'hffffff, 24'hffffff, 23'h7fffff, 1, 23'h7fffff, 4095,
              make_control(SHAPE_TRAPEZE, 0, 1, 1, 0, 65535));
    send_tick(24'sh7fffff);
    send_tick(-24'sh800000);
    configure(0, 0, 0, 0, 0, 0, 4095, make_control(SHAPE_MODSINE, 0, 0, 0, 1, 65535));
    send_tick(24'sh0);
    send_tick(24'sh1);
  endtask

  task automatic test_backpressure();
    configure(23'h4000, 24'h2000, 24'h100, 23'h1000, 30, 0, 4095,
              make_control(SHAPE_SINE, 0, 0, 0, 127, 65535));
    src_idle = 0;
    sink_hold = 400;
    run_tracking(40);
    drain();
  endtask

  task automatic test_random();
    int count;
    longint amp, pg, ig, il, len, slp, dlim;
    logic [27:0] ctl;
    while (sent_count < ITEM_TARGET) begin
      src_idle = $urandom_range(0, 2) != 0;
      sink_idle = $urandom_range(0, 2) != 0;
      amp = ($urandom_range(0, 9) == 0) ? 23'h7fffff : $urandom_range(0, 23'h100000);
      pg = ($urandom_range(0, 9) == 0) ? 24'hffffff : $urandom_range(0, 24'h20000);
      ig = ($urandom_range(0, 9) == 0) ? 24'hffffff : $urandom_range(0, 24'h2000);
      il = ($urandom_range(0, 9) == 0) ? 23'h7fffff : $urandom_range(0, 23'h20000);
      case ($urandom_range(0, 9))
        0:       len = 0;
        1:       len = 65535;
        default: len = $urandom_range(1, 300);
      endcase
      slp = ($urandom_range(0, 9) == 0) ? $urandom & 23'h7fffff
                                        : $urandom_range(1, amp / 8 + 1);
      case ($urandom_range(0, 5))
        0:       dlim = 0;
        1:       dlim = $urandom_range(0, 4095);
        default: dlim = 4095;
      endcase
      ctl = make_control($urandom_range(0, 3), $urandom_range(0, 9) == 0,
                         $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0,
                         ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : 127,
                         ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8)
                                                     : $urandom_range(9, 65535));
      configure(amp, pg, ig, il, len, slp, dlim, ctl);
      count = $urandom_range(10, 150);
      repeat (count) begin
        if ($urandom_range(0, 99) < 85) send_tick(tracking_current());
        else send_tick(24'($urandom));
      end
    end
  endtask

  // result sink
  initial begin
    int gap;
    out_ready = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (sink_hold > 0) begin
        out_ready <= 1'b0;
        repeat (sink_hold) @(posedge clk);
        sink_hold = 0;
      end
      gap = sink_idle ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    tick_result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $error("result transfer with nothing expected");
        failures++;
      end else begin
        e = expected_q.pop_front();
        if (out_dac_code !== e.dac) begin
          $error("dac_code expected %0d actual %0d", e.dac, out_dac_code);
          failures++;
        end
        if (out_setpoint_current !== e.setpoint) begin
          $error("setpoint_current expected %0d actual %0d", e.setpoint,
                 out_setpoint_current);
          failures++;
        end
        if (out_drive_value !== e.drive) begin
          $error("drive_value expected %0d actual %0d", e.drive, out_drive_value);
          failures++;
        end
        if (out_control_error !== e.error) begin
          $error("control_error expected %0d actual %0d", e.error, out_control_error);
          failures++;
        end
        if (out_following_fault !== e.fault) begin
          $error("following_fault expected %0d actual %0d", e.fault, out_following_fault);
          failures++;
        end
        if (out_pulse_done !== e.done) begin
          $error("pulse_done expected %0d actual %0d", e.done, out_pulse_done);
          failures++;
        end
        if (out_flattop_end_tick !== e.flat_end) begin
          $error("flattop_end_tick expected %0d actual %0d", e.flat_end,
                 out_flattop_end_tick);
          failures++;
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_measured_current = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    amplitude = 0;
    p_gain = 0;
    i_gain = 0;
    i_limit = 0;
    pulse_len = 1;
    slope = 0;
    dac_limit = 4095;
    control = '0;
    restart_pulse();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_sine();
    test_modified_sine();
    test_trapeze();
    test_bad_shape();
    test_fault_latch();
    test_extremes();
    test_backpressure();
    test_random();
    drain();
    if (failures == 0) begin
      $display("pulse_current_pi_regulator_top: match");
    end else begin
      $display("pulse_current_pi_regulator_top: mismatch");
    end
    $finish;
  end

endmodule
